### src/ntaf_pkg.sv
`default_nettype none

package ntaf_pkg;

  typedef enum logic [1:0] {
    OP_DEC  = 2'd0,
    OP_HEX  = 2'd1,
    OP_BIN  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEC,
    ST_HEX,
    ST_BIN
  } state_e;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] HEX_GAP  = 8'd7;

  localparam logic [2:0] DEC_LAST_PLACE = 3'd4;
  localparam logic [3:0] HEX_DIGITS     = 4'd4;
  localparam logic [4:0] BIN_DIGITS     = 5'd16;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       last;
  } beat_t;

  function automatic logic [16:0] place_weight(input logic [2:0] place);
    logic [16:0] w;
    unique case (place)
      3'd0:    w = 17'd10000;
      3'd1:    w = 17'd1000;
      3'd2:    w = 17'd100;
      3'd3:    w = 17'd10;
      default: w = 17'd1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### src/ntaf_dec_digit.sv
`default_nettype none

module ntaf_dec_digit (
  input  wire logic [15:0] mag_i,
  input  wire logic [2:0]  place_i,
  output logic      [3:0]  digit_o,
  output logic      [15:0] rem_o
);

  logic [16:0] weight;
  logic [16:0] mult [10];

  assign weight = ntaf_pkg::place_weight(place_i);

  always_comb begin
    for (int k = 0; k < 10; k++) begin
      mult[k] = 17'(weight * 17'(k));
    end
  end

  always_comb begin
    digit_o = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({1'b0, mag_i} >= mult[k]) begin
        digit_o = 4'(k);
      end
    end
  end

  assign rem_o = 16'({1'b0, mag_i} - mult[digit_o]);

endmodule

`default_nettype wire

### src/ntaf_seq.sv
`default_nettype none

module ntaf_seq (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] value_i,
  output logic             busy,
  output ntaf_pkg::beat_t  beat_o
);

  ntaf_pkg::state_e state_q, state_d;
  logic [15:0] word_q, word_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        started_q, started_d;
  logic        neg_q, neg_d;

  logic [3:0]  digit;
  logic [15:0] rem;
  logic [2:0]  place;
  logic [3:0]  nib;
  logic        first_sig;
  logic        accept;
  ntaf_pkg::op_e op;

  assign place     = cnt_q[2:0];
  assign nib       = word_q[15:12];
  assign first_sig = (digit != 4'd0) || (place == ntaf_pkg::DEC_LAST_PLACE);
  assign op        = ntaf_pkg::op_e'(op_i);

  ntaf_dec_digit u_dec_digit (
    .mag_i   (word_q),
    .place_i (place),
    .digit_o (digit),
    .rem_o   (rem)
  );

  always_comb begin
    beat_o = '0;
    unique case (state_q)
      ntaf_pkg::ST_DEC: begin
        beat_o.valid = 1'b1;
        if (started_q) begin
          beat_o.ch   = ntaf_pkg::CH_ZERO + {4'd0, digit};
          beat_o.last = (place == ntaf_pkg::DEC_LAST_PLACE);
        end else if (first_sig) begin
          beat_o.ch = neg_q ? ntaf_pkg::CH_MINUS : ntaf_pkg::CH_SPACE;
        end else begin
          beat_o.ch = ntaf_pkg::CH_SPACE;
        end
      end
      ntaf_pkg::ST_HEX: begin
        beat_o.valid = 1'b1;
        beat_o.ch    = ntaf_pkg::CH_ZERO + {4'd0, nib}
                     + ((nib >= 4'd10) ? ntaf_pkg::HEX_GAP : 8'd0);
        beat_o.last  = (cnt_q == 4'd0);
      end
      ntaf_pkg::ST_BIN: begin
        beat_o.valid = 1'b1;
        beat_o.ch    = ntaf_pkg::CH_ZERO + {7'd0, word_q[15]};
        beat_o.last  = (cnt_q == 4'd0);
      end
      default: begin
        beat_o = '0;
      end
    endcase
  end

  assign busy   = beat_o.valid && !beat_o.last;
  assign accept = start && !busy;

  always_comb begin
    state_d   = state_q;
    word_d    = word_q;
    cnt_d     = cnt_q;
    started_d = started_q;
    neg_d     = neg_q;
    if (accept) begin
      word_d    = value_i;
      started_d = 1'b0;
      neg_d     = 1'b0;
      cnt_d     = 4'd0;
      unique case (op)
        ntaf_pkg::OP_DEC: begin
          state_d = ntaf_pkg::ST_DEC;
          neg_d   = value_i[15];
          word_d  = value_i[15] ? 16'(~value_i + 16'd1) : value_i;
        end
        ntaf_pkg::OP_HEX: begin
          state_d = ntaf_pkg::ST_HEX;
          cnt_d   = ntaf_pkg::HEX_DIGITS - 4'd1;
        end
        ntaf_pkg::OP_BIN: begin
          state_d = ntaf_pkg::ST_BIN;
          cnt_d   = 4'(ntaf_pkg::BIN_DIGITS - 5'd1);
        end
        default: begin
          state_d = ntaf_pkg::ST_IDLE;
        end
      endcase
    end else if (beat_o.valid && beat_o.last) begin
      state_d = ntaf_pkg::ST_IDLE;
    end else begin
      unique case (state_q)
        ntaf_pkg::ST_DEC: begin
          if (started_q) begin
            word_d = rem;
            cnt_d  = cnt_q + 4'd1;
          end else if (first_sig) begin
            started_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
        ntaf_pkg::ST_HEX: begin
          word_d = {word_q[11:0], 4'd0};
          cnt_d  = cnt_q - 4'd1;
        end
        ntaf_pkg::ST_BIN: begin
          word_d = {word_q[14:0], 1'b0};
          cnt_d  = cnt_q - 4'd1;
        end
        default: begin
          state_d = ntaf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ntaf_pkg::ST_IDLE;
      started_q <= 1'b0;
      cnt_q     <= 4'd0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    neg_q  <= neg_d;
  end

endmodule

`default_nettype wire

### src/number_to_ascii_formatter.sv
// Prints a 16-bit word as ASCII, one character per out_valid_o cycle, most
// significant place first, with last_o on the final character. The receiver
// cannot stall: every character is on the ports for exactly one cycle. An item
// is taken when start is high and busy is low; its first character passes the
// state register, then the output register. Decimal gives 6, hex 4 and binary
// 16 characters, one per cycle from the sequencer; busy drops in the cycle
// before the final character of an item reaches the ports, so the next one
// follows without a gap. Format code 3 gives no output and leaves busy low.
`default_nettype none

module number_to_ascii_formatter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] value_i,
  output logic             out_valid_o,
  output logic [7:0]       out_char_o,
  output logic             last_o
);

  ntaf_pkg::beat_t beat;
  logic            valid_q;
  logic [7:0]      char_q;
  logic            last_q;

  ntaf_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .op_i    (op_i),
    .value_i (value_i),
    .busy    (busy),
    .beat_o  (beat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= beat.ch;
    last_q <= beat.last;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### sim/testbench.sv
`default_nettype none

module testbench;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  class char_checker;
    char_beat_t pending_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function automatic void push_char(logic [7:0] ch);
      char_beat_t b;
      b.ch   = ch;
      b.last = 1'b0;
      pending_chars.push_back(b);
    endfunction

    function automatic void note_word(ntaf_pkg::op_e op, logic [15:0] word);
      int unsigned weights[5] = '{10000, 1000, 100, 10, 1};
      int unsigned mag;
      int unsigned digit;
      int unsigned n_before;
      logic [7:0]  sign_ch;
      bit          started;
      n_before = pending_chars.size();
      case (op)
        ntaf_pkg::OP_DEC: begin
          sign_ch = ntaf_pkg::CH_SPACE;
          mag     = 32'(word);
          started = 1'b0;
          if (word[15]) begin
            sign_ch = ntaf_pkg::CH_MINUS;
            mag     = 32'h10000 - 32'(word);
          end
          for (int i = 0; i < 5; i++) begin
            digit = mag / weights[i];
            mag   = mag % weights[i];
            if (digit != 0 || started || i == 4) begin
              if (!started) push_char(sign_ch);
              started = 1'b1;
              push_char(ntaf_pkg::CH_ZERO + 8'(digit));
            end else begin
              push_char(ntaf_pkg::CH_SPACE);
            end
          end
        end
        ntaf_pkg::OP_HEX: begin
          for (int p = 3; p >= 0; p--) begin
            digit = 32'(word[p*4 +: 4]);
            push_char(ntaf_pkg::CH_ZERO + 8'(digit)
                      + ((digit >= 10) ? ntaf_pkg::HEX_GAP : 8'd0));
          end
        end
        ntaf_pkg::OP_BIN: begin
          for (int p = 15; p >= 0; p--) push_char(ntaf_pkg::CH_ZERO + 8'(word[p]));
        end
        default: begin
        end
      endcase
      if (pending_chars.size() > n_before)
        pending_chars[pending_chars.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_char(logic [7:0] ch, logic last);
      char_beat_t exp_b;
      if (pending_chars.size() == 0) begin
        $error("unexpected beat: out_char %h last %b", ch, last);
        errors++;
        return;
      end
      exp_b = pending_chars.pop_front();
      if (ch !== exp_b.ch) begin
        $error("out_char: expected %h, got %h", exp_b.ch, ch);
        errors++;
      end
      if (last !== exp_b.last) begin
        $error("last: expected %b, got %b", exp_b.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  op_i;
  logic [15:0] value_i;
  logic        out_valid_o;
  logic [7:0]  out_char_o;
  logic        last_o;

  char_checker chk = new();

  number_to_ascii_formatter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .op_i       (op_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_char_o (out_char_o),
    .last_o     (last_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) chk.check_char(out_char_o, last_o);
  end

  task automatic send_word(input ntaf_pkg::op_e op, input logic [15:0] word);
    start   <= 1'b1;
    op_i    <= op;
    value_i <= word;
    do @(posedge clk_i); while (busy);
    chk.note_word(op, word);
  endtask

  task automatic idle_burst();
    start   <= 1'b0;
    op_i    <= 2'($urandom);
    value_i <= 16'($urandom);
    repeat ($urandom_range(1, 9)) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_word();
    logic [15:0] extremes[6] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001,
                                  16'h8001};
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return extremes[$urandom_range(0, 5)];
    if (sel <= 2) return 16'($urandom_range(0, 400)) - 16'd200;
    if (sel == 3) return 16'($urandom_range(0, 40000)) - 16'd20000;
    return 16'($urandom);
  endfunction

  initial begin
    ntaf_pkg::op_e op_pick;
    logic [15:0] dec_words[14] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                                   16'd9, 16'd10, 16'd99, 16'd100, 16'd12345,
                                   16'hFFFB, 16'hD8F0, 16'd10000, 16'd9999};
    logic [15:0] hex_words[4]  = '{16'h0000, 16'hFFFF, 16'h1234, 16'hAB9F};
    logic [15:0] bin_words[3]  = '{16'h0000, 16'hFFFF, 16'hA5C3};
    int          n_random;
    rst_ni  = 1'b0;
    start   = 1'b0;
    op_i    = ntaf_pkg::OP_DEC;
    value_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dec_words[i]) send_word(ntaf_pkg::OP_DEC, dec_words[i]);
    foreach (hex_words[i]) send_word(ntaf_pkg::OP_HEX, hex_words[i]);
    foreach (bin_words[i]) send_word(ntaf_pkg::OP_BIN, bin_words[i]);
    send_word(ntaf_pkg::OP_NONE, 16'hFFFF);
    idle_burst();
    send_word(ntaf_pkg::OP_NONE, 16'h0000);
    send_word(ntaf_pkg::OP_DEC, 16'h8000);

    n_random = 446;
    for (int k = 0; k < n_random; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op_pick = ntaf_pkg::OP_DEC;
        4, 5, 6:    op_pick = ntaf_pkg::OP_HEX;
        7, 8:       op_pick = ntaf_pkg::OP_BIN;
        default:    op_pick = ntaf_pkg::OP_NONE;
      endcase
      send_word(op_pick, pick_word());
      if (k < n_random - 80 && $urandom_range(0, 3) == 0) idle_burst();
    end
    start <= 1'b0;

    while (chk.pending_chars.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);

    if (chk.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
